/* rtl/aat_pkg.sv */
// Package for the adaptive admission throttle: widths, register indexes,
// function, reason and breaker state codes. No dependencies.
`default_nettype none
package aat_pkg;
    localparam int RingDepth = 64;
    localparam int RingAw    = $clog2(RingDepth);
    localparam int FillW     = $clog2(RingDepth + 1);

    typedef enum logic [1:0] {
        FN_TICK    = 2'd0,
        FN_QUERY   = 2'd1,
        FN_SUCCESS = 2'd2,
        FN_FAILURE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        RSN_NONE    = 3'd0,
        RSN_BREAKER = 3'd1,
        RSN_CYCLE   = 3'd2,
        RSN_BURST   = 3'd3,
        RSN_SPACING = 3'd4
    } reason_t;

    localparam logic [2:0] REG_BASE     = 3'd0;
    localparam logic [2:0] REG_MIN      = 3'd1;
    localparam logic [2:0] REG_MAX      = 3'd2;
    localparam logic [2:0] REG_WINDOW   = 3'd3;
    localparam logic [2:0] REG_BURST    = 3'd4;
    localparam logic [2:0] REG_PERCYCLE = 3'd5;
    localparam logic [2:0] REG_GAINS    = 3'd6;
    localparam logic [2:0] REG_FEATURES = 3'd7;

    // Breaker states: probing doubles the spacing, open blocks.
    localparam logic [1:0] CS_PROBE = 2'd1;
    localparam logic [1:0] CS_OPEN  = 2'd2;
endpackage
`default_nettype wire

/* rtl/adaptive_admission_throttle.sv */
// Adaptive admission throttle top level: control sequencer, timestamp ring
// memory and serial divider for the spacing. Depends on aat_pkg.
`default_nettype none
// Usage:
// Requests enter on s_axis (tuser: func; tdata: now_ms, pressure_level,
// circuit_state, breaker_allows from bit 0 up). Each request gives exactly one
// result on m_axis. Registers are written on the cfg channel (cfg_index,
// cfg_data); the user must write them only while the block is idle; the block
// itself does not enforce this. Query, success and failure requests go
// straight to the done step, so their result register is loaded when that step
// completes. A tick walks the ring from the oldest entry: a read-request step,
// then a compare step that drops the entry if it is older than the window, at
// most 64 entries, until an entry is in the window or the ring empties. Then
// a release step and, with adaptive mode on, the divider steps (ended at once
// when blocked) and a clamp step, then the done step.
// s_axis_tready is high only while idle. The result register holds a result
// until m_axis_tready; a new request may be accepted meanwhile, and its done
// step waits while the register is still full.
// Reset clears all counters and the configuration registers to their defaults;
// the ring memory needs no clearing since only filled entries are read.
module adaptive_admission_throttle (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // func[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // now_ms[31:0], pressure_level[33:32], circuit_state[35:34],
    // breaker_allows[36], zero pad to 40 bits
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // allowed[0], block_reason[3:1], wait_ms[19:4], interval_ms[35:20],
    // recent_admissions[42:36], cycle_admissions[50:43],
    // failures_total[82:51], burst_releases[114:83], zero pad to 120 bits
    output logic [119:0]     m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import aat_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RDREQ = 7'b0000010,
        ST_PRUNE = 7'b0000100,
        ST_REL   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_CLAMP = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] base_reg, min_reg, max_reg;
    logic [19:0] window_reg;
    logic [6:0]  burst_reg;
    logic [7:0]  percycle_reg;
    logic [31:0] gains_reg;
    logic [2:0]  feat_reg;

    logic [31:0] last_reg;
    logic [15:0] spacing_reg;
    logic [RingAw-1:0] oldest_reg;
    logic [FillW-1:0]  fill_reg, fill_start_reg;
    logic [7:0]  cycle_reg;
    logic [31:0] fail_reg, rel_reg;

    logic [1:0]  func_reg, level_reg, cs_reg;
    logic [31:0] now_reg;
    logic        allows_reg;

    logic [31:0] ring_mem [RingDepth];
    logic [31:0] rd_data_reg;
    logic        wr_en;
    logic [RingAw-1:0] wr_addr;

    // Divider: 24-bit dividend (base*32 fits), 8-bit divisor.
    logic [23:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  div_reg;
    logic [4:0]  cnt_reg;
    logic        blocked_reg;

    logic        out_valid_reg;
    logic [119:0] out_data_reg;

    logic [31:0] elapsed;
    logic [31:0] age;
    logic [9:0]  rem_shift;
    logic [7:0]  gain_sel;
    logic        k_double;
    logic [23:0] quo_hi_chk;
    logic [15:0] clamp_v;
    reason_t     reason;
    logic        busy_free;
    logic        done_go;

    assign busy_free     = (state_reg == ST_IDLE);
    assign s_axis_tready = busy_free;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign done_go       = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign elapsed  = now_reg - last_reg;
    assign age      = now_reg - rd_data_reg;
    assign gain_sel = gains_reg[{level_reg, 3'b000} +: 8];
    assign k_double = feat_reg[1] && (cs_reg == CS_PROBE);
    assign rem_shift = {rem_reg, quo_reg[23]};
    assign quo_hi_chk = quo_reg;

    always_comb
    begin
        logic [23:0] v;
        v = blocked_reg ? {8'd0, max_reg} : quo_hi_chk;
        if (v < {8'd0, min_reg})
            v = {8'd0, min_reg};
        if (v > {8'd0, max_reg})
            v = {8'd0, max_reg};
        clamp_v = v[15:0];
    end

    always_comb
    begin
        priority if (feat_reg[1] && !allows_reg)
            reason = RSN_BREAKER;
        else if (cycle_reg >= percycle_reg)
            reason = RSN_CYCLE;
        else if (feat_reg[2] && ({1'b0, fill_reg} >= {1'b0, burst_reg}))
            reason = RSN_BURST;
        else if (elapsed < {16'd0, spacing_reg})
            reason = RSN_SPACING;
        else
            reason = RSN_NONE;
    end

    // Ring write happens on the success request when the done step completes.
    assign wr_en   = done_go && (func_reg == FN_SUCCESS);
    assign wr_addr = (fill_reg == FillW'(RingDepth)) ? oldest_reg
                     : RingAw'(oldest_reg + RingAw'(fill_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wr_addr] <= now_reg;
        rd_data_reg <= ring_mem[oldest_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = (s_axis_tuser == FN_TICK) ? ST_RDREQ : ST_DONE;
            ST_RDREQ:
                state_next = (fill_reg == '0) ? ST_REL : ST_PRUNE;
            ST_PRUNE:
                state_next = (age <= {12'd0, window_reg}) ? ST_REL : ST_RDREQ;
            ST_REL:
                state_next = feat_reg[0] ? ST_DIV : ST_DONE;
            ST_DIV:
                if (blocked_reg || cnt_reg == 5'd0)
                    state_next = ST_CLAMP;
            ST_CLAMP:
                state_next = ST_DONE;
            ST_DONE:
                if (done_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= 16'd100;
            min_reg       <= 16'd50;
            max_reg       <= 16'd5000;
            window_reg    <= 20'd10000;
            burst_reg     <= 7'd50;
            percycle_reg  <= 8'd1;
            gains_reg     <= 32'h0040_2010;
            feat_reg      <= 3'd7;
            last_reg      <= '0;
            spacing_reg   <= 16'd100;
            oldest_reg    <= '0;
            fill_reg      <= '0;
            fill_start_reg <= '0;
            cycle_reg     <= '0;
            fail_reg      <= '0;
            rel_reg       <= '0;
            out_valid_reg <= 1'b0;
            blocked_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BASE:     base_reg     <= cfg_data[15:0];
                    REG_MIN:      min_reg      <= cfg_data[15:0];
                    REG_MAX:      max_reg      <= cfg_data[15:0];
                    REG_WINDOW:   window_reg   <= cfg_data[19:0];
                    REG_BURST:    burst_reg    <= cfg_data[6:0];
                    REG_PERCYCLE: percycle_reg <= cfg_data[7:0];
                    REG_GAINS:    gains_reg    <= cfg_data;
                    REG_FEATURES: feat_reg     <= cfg_data[2:0];
                    default:      ;
                endcase
            end
            if (done_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    fill_start_reg <= fill_reg;
                ST_PRUNE:
                    if (age > {12'd0, window_reg})
                    begin
                        oldest_reg <= RingAw'(oldest_reg + 1'b1);
                        fill_reg   <= FillW'(fill_reg - 1'b1);
                    end
                ST_REL:
                begin
                    if ({1'b0, fill_start_reg} >= {1'b0, burst_reg}
                        && {1'b0, fill_reg} < {1'b0, burst_reg}
                        && rel_reg != '1)
                        rel_reg <= rel_reg + 32'd1;
                    blocked_reg <= (gain_sel == 8'd0)
                                   || (feat_reg[1] && cs_reg == CS_OPEN);
                    cnt_reg <= 5'd24;
                end
                ST_DIV:
                    if (!blocked_reg)
                        cnt_reg <= cnt_reg - 5'd1;
                ST_CLAMP:
                    spacing_reg <= clamp_v;
                ST_DONE:
                    if (done_go)
                    begin
                        unique case (func_reg)
                            FN_TICK:    cycle_reg <= '0;
                            FN_SUCCESS:
                            begin
                                last_reg <= now_reg;
                                if (fill_reg == FillW'(RingDepth))
                                    oldest_reg <= RingAw'(oldest_reg + 1'b1);
                                else
                                    fill_reg <= FillW'(fill_reg + 1'b1);
                                if (cycle_reg != 8'hFF)
                                    cycle_reg <= cycle_reg + 8'd1;
                            end
                            FN_FAILURE:
                                if (fail_reg != '1)
                                    fail_reg <= fail_reg + 32'd1;
                            default: ;
                        endcase
                    end
                default: ;
            endcase
        end
    end

    // Payload registers: request capture, divider datapath and result.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg   <= s_axis_tuser;
            now_reg    <= s_axis_tdata[31:0];
            level_reg  <= s_axis_tdata[33:32];
            cs_reg     <= s_axis_tdata[35:34];
            allows_reg <= s_axis_tdata[36];
        end
        if (state_reg == ST_REL)
        begin
            quo_reg <= k_double ? {3'd0, base_reg, 5'd0} : {4'd0, base_reg, 4'd0};
            rem_reg <= '0;
            div_reg <= gain_sel;
        end
        else if (state_reg == ST_DIV && !blocked_reg && cnt_reg != 5'd0)
        begin
            if (rem_shift >= {2'd0, div_reg})
            begin
                rem_reg <= 9'(rem_shift - {2'd0, div_reg});
                quo_reg <= {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[8:0];
                quo_reg <= {quo_reg[22:0], 1'b0};
            end
        end
        if (done_go)
        begin
            // Status fields are sampled after the update, so compute them here.
            logic [FillW-1:0] f;
            logic [7:0]  c;
            logic [31:0] fl;
            logic [31:0] lt;
            logic [31:0] el;
            logic [15:0] w;
            f  = fill_reg;
            c  = cycle_reg;
            fl = fail_reg;
            lt = last_reg;
            unique case (func_reg)
                FN_TICK:    c = '0;
                FN_SUCCESS:
                begin
                    lt = now_reg;
                    if (fill_reg != FillW'(RingDepth))
                        f = FillW'(fill_reg + 1'b1);
                    if (cycle_reg != 8'hFF)
                        c = cycle_reg + 8'd1;
                end
                FN_FAILURE:
                    if (fail_reg != '1)
                        fl = fail_reg + 32'd1;
                default: ;
            endcase
            el = now_reg - lt;
            w  = (el < {16'd0, spacing_reg}) ? 16'(32'(spacing_reg) - el) : 16'd0;
            out_data_reg <= {5'd0, rel_reg, fl, c, 7'(f), spacing_reg, w,
                             (func_reg == FN_QUERY) ? reason : RSN_NONE,
                             (func_reg == FN_QUERY) && (reason == RSN_NONE)};
        end
    end

    a_one_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result changed");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillW'(RingDepth)) else $error("ring fill overflow");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_go |=> out_valid_reg) else $error("result lost");
endmodule
`default_nettype wire

/* sim/adaptive_admission_throttle_tb.sv */
// Self-checking testbench for adaptive_admission_throttle: a queue-fed request driver,
// a result monitor with its own throttle predictor, and phased register settings.
// Depends on aat_pkg and the RTL top level only.
module adaptive_admission_throttle_tb;
    import aat_pkg::*;

    localparam int IdleLimit  = 3000;
    localparam int TickSettle = 200;

    // Fields from the highest result bit down to bit 0.
    typedef struct packed {
        logic [31:0] releases;
        logic [31:0] failures;
        logic [7:0]  cycle_adm;
        logic [6:0]  recent;
        logic [15:0] interval_ms;
        logic [15:0] wait_ms;
        reason_t     reason;
        logic        allowed;
    } verdict_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    adaptive_admission_throttle i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Throttle settings and state as the predictor sees them.
    logic [15:0] base_ms, min_ms, max_ms;
    logic [19:0] window_ms;
    logic [6:0]  burst_lim;
    logic [7:0]  cycle_lim;
    logic [31:0] gains;
    logic [2:0]  features;
    logic [31:0] last_admit;
    logic [15:0] spacing;
    logic [31:0] stamps [RingDepth];
    logic [5:0]  oldest;
    logic [6:0]  fill;
    logic [7:0]  cycle_cnt;
    logic [31:0] fail_cnt, release_cnt;

    // Request layout: func[1:0], now_ms[33:2], level[35:34], cstate[37:36], allow[38].
    logic [39:0] pending_reqs [$];
    verdict_t    expected_verdicts [$];
    logic [31:0] cur_time;
    int          err_count, req_count, admit_count, release_seen, idle_cycles;
    int          burst_left, gap_left, stall_cycle;
    int          reason_hits [5];

    function automatic logic [15:0] spacing_for(logic [1:0] level, logic [1:0] cstate);
        logic [7:0]  g;
        logic [1:0]  k;
        logic        blocked;
        logic [63:0] v;
        g = gains[level*8 +: 8];
        k = 2'd1;
        blocked = (g == 8'd0);
        if (features[1]) begin
            if (cstate == CS_OPEN)
                blocked = 1'b1;
            else if (cstate == CS_PROBE)
                k = 2'd2;
        end
        v = blocked ? 64'(max_ms) : (64'(base_ms) * 16 * k) / g;
        if (v < min_ms)
            v = min_ms;
        if (v > max_ms)
            v = max_ms;
        return v[15:0];
    endfunction

    function automatic verdict_t throttle_step(logic [39:0] req);
        func_t       fn;
        logic [31:0] now, elapsed;
        logic [6:0]  prior;
        verdict_t    v;
        fn  = func_t'(req[1:0]);
        now = req[33:2];
        v = '0;
        v.reason = RSN_NONE;
        case (fn)
            FN_TICK:
            begin
                prior = fill;
                while (fill > 0 && (now - stamps[oldest]) > 32'(window_ms)) begin
                    oldest = oldest + 1;
                    fill = fill - 1;
                end
                if (prior >= burst_lim && fill < burst_lim && release_cnt != '1)
                    release_cnt = release_cnt + 1;
                if (features[0])
                    spacing = spacing_for(req[35:34], req[37:36]);
                cycle_cnt = 0;
            end
            FN_QUERY:
            begin
                elapsed = now - last_admit;
                if (features[1] && !req[38])
                    v.reason = RSN_BREAKER;
                else if (cycle_cnt >= cycle_lim)
                    v.reason = RSN_CYCLE;
                else if (features[2] && fill >= burst_lim)
                    v.reason = RSN_BURST;
                else if (elapsed < 32'(spacing))
                    v.reason = RSN_SPACING;
                v.allowed = (v.reason == RSN_NONE);
            end
            FN_SUCCESS:
            begin
                last_admit = now;
                if (fill < RingDepth) begin
                    stamps[6'(oldest + fill)] = now;
                    fill = fill + 1;
                end else begin
                    stamps[oldest] = now;
                    oldest = oldest + 1;
                end
                if (cycle_cnt != 8'hFF)
                    cycle_cnt = cycle_cnt + 1;
            end
            default:
            begin
                if (fail_cnt != '1)
                    fail_cnt = fail_cnt + 1;
            end
        endcase
        elapsed = now - last_admit;
        v.wait_ms     = (elapsed < 32'(spacing)) ? 16'(32'(spacing) - elapsed) : 16'd0;
        v.interval_ms = spacing;
        v.recent      = fill;
        v.cycle_adm   = cycle_cnt;
        v.failures    = fail_cnt;
        v.releases    = release_cnt;
        return v;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_BASE:     base_ms   = d[15:0];
            REG_MIN:      min_ms    = d[15:0];
            REG_MAX:      max_ms    = d[15:0];
            REG_WINDOW:   window_ms = d[19:0];
            REG_BURST:    burst_lim = d[6:0];
            REG_PERCYCLE: cycle_lim = d[7:0];
            REG_GAINS:    gains     = d;
            REG_FEATURES: features  = d[2:0];
            default:      ;
        endcase
    endfunction

    function automatic void check_field(string name, longint unsigned exp, longint unsigned act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            err_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= '0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0][1:0];
                s_axis_tdata  <= {2'b00, pending_reqs[0][39:2]};
                pending_reqs.delete(0);
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: the stall mode steps in turn through four patterns.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_cycle   <= 0;
        end else begin
            stall_cycle <= stall_cycle + 1;
            case ((stall_cycle / 128) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (stall_cycle % 23) > 15;
                default: m_axis_tready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    // Monitor: results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        verdict_t exp_v, got;
        logic     moved;
        moved = 1'b0;
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                got = verdict_t'(m_axis_tdata[114:0]);
                if (expected_verdicts.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    exp_v = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    check_field("allowed", exp_v.allowed, got.allowed);
                    check_field("block_reason", exp_v.reason, got.reason);
                    check_field("wait_ms", exp_v.wait_ms, got.wait_ms);
                    check_field("interval_ms", exp_v.interval_ms, got.interval_ms);
                    check_field("recent_admissions", exp_v.recent, got.recent);
                    check_field("cycle_admissions", exp_v.cycle_adm, got.cycle_adm);
                    check_field("failures_total", exp_v.failures, got.failures);
                    check_field("burst_releases", exp_v.releases, got.releases);
                    if (m_axis_tdata[119:115] != '0) begin
                        $error("pad bits: expected 0, got %0h", m_axis_tdata[119:115]);
                        err_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                exp_v = throttle_step({s_axis_tdata[37:0], s_axis_tuser});
                expected_verdicts = {expected_verdicts, exp_v};
                req_count++;
                reason_hits[exp_v.reason]++;
                if (s_axis_tuser == FN_SUCCESS)
                    admit_count++;
                if (exp_v.releases != 0)
                    release_seen = 1;
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                apply_reg(cfg_index, cfg_data);
            end
            if (idle_cycles >= IdleLimit) begin
                $display("adaptive_admission_throttle_tb: errors");
                $finish;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    task automatic push_req(func_t fn, logic [31:0] now, logic [1:0] level,
                            logic [1:0] cstate, logic allow);
        logic [39:0] req;
        req = {1'b0, allow, cstate, level, now, fn};
        pending_reqs = {pending_reqs, req};
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every request has been answered, then lets a tick settle.
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (TickSettle) @(negedge clk);
    endtask

    // Mostly admission attempts (query then success at the same time), with
    // ticks, failures, lone requests and occasional random time jumps.
    task automatic gen_traffic(int n, int step_max, int tick_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) == 0)
                cur_time = $urandom;
            else
                cur_time = cur_time + $urandom_range(0, step_max);
            if (r < tick_pct)
                push_req(FN_TICK, cur_time, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else if (r < 70) begin
                push_req(FN_QUERY, cur_time, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0);
                push_req(FN_SUCCESS, cur_time, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                i++;
            end else if (r < 80)
                push_req(FN_QUERY, cur_time, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else if (r < 90)
                push_req(FN_SUCCESS, cur_time, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else
                push_req(FN_FAILURE, cur_time, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE;
        cfg_data  = '0;
        err_count = 0;
        req_count = 0;
        admit_count = 0;
        release_seen = 0;
        foreach (reason_hits[i])
            reason_hits[i] = 0;
        base_ms = 100; min_ms = 50; max_ms = 5000; window_ms = 10000;
        burst_lim = 50; cycle_lim = 1; gains = 32'h0040_2010; features = 3'd7;
        last_admit = '0; spacing = 100; oldest = '0; fill = '0;
        cycle_cnt = '0; fail_cnt = '0; release_cnt = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at reset settings.
        push_req(FN_QUERY,   32'd10,  2'd0, 2'd0, 1'b0);
        push_req(FN_QUERY,   32'd20,  2'd0, 2'd0, 1'b1);
        push_req(FN_QUERY,   32'd200, 2'd3, 2'd3, 1'b1);
        push_req(FN_SUCCESS, 32'd200, 2'd0, 2'd0, 1'b1);
        push_req(FN_QUERY,   32'd400, 2'd0, 2'd0, 1'b1);
        push_req(FN_FAILURE, 32'd401, 2'd0, 2'd0, 1'b0);
        push_req(FN_TICK,    32'd410, 2'd1, 2'd1, 1'b1);
        push_req(FN_QUERY,   32'd420, 2'd0, 2'd0, 1'b1);
        push_req(FN_TICK,    32'd430, 2'd3, 2'd0, 1'b1);
        push_req(FN_TICK,    32'd440, 2'd2, 2'd2, 1'b1);
        push_req(FN_TICK,    32'd450, 2'd2, 2'd3, 1'b1);
        push_req(FN_TICK,    32'd460, 2'd0, 2'd0, 1'b0);
        push_req(FN_SUCCESS, 32'hFFFF_FFF0, 2'd0, 2'd0, 1'b1);
        push_req(FN_TICK,    32'h0000_0005, 2'd0, 2'd0, 1'b1);
        push_req(FN_QUERY,   32'h0000_0010, 2'd0, 2'd0, 1'b1);
        push_req(FN_QUERY,   32'h0000_0100, 2'd1, 2'd1, 1'b1);
        push_req(FN_SUCCESS, 32'h0000_0100, 2'd0, 2'd0, 1'b1);
        push_req(FN_TICK,    32'h0000_3000, 2'd0, 2'd0, 1'b1);
        push_req(FN_FAILURE, 32'hFFFF_FFFF, 2'd3, 2'd3, 1'b1);
        drain();

        // Small window and burst limit, so the ring fills and releases often.
        write_reg(REG_PERCYCLE, 32'd255);
        write_reg(REG_BURST, 32'd10);
        write_reg(REG_WINDOW, 32'd500);
        write_reg(REG_GAINS, $urandom);
        write_reg(REG_BASE, 32'd40);
        write_reg(REG_MIN, 32'd5);
        write_reg(REG_MAX, 32'd300);
        cur_time = 32'd1000;
        gen_traffic(260, 40, 12);
        drain();

        // Extremes; wide writes, crossed clamps off, all features off.
        write_reg(REG_BASE, 32'hFFFF_FFFF);
        write_reg(REG_MIN, 32'd0);
        write_reg(REG_MAX, 32'hFFFF);
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        write_reg(REG_BURST, 32'hFFFF_FFFF);
        write_reg(REG_PERCYCLE, 32'd0);
        write_reg(REG_GAINS, 32'hFFFF_FFFF);
        write_reg(REG_FEATURES, 32'd0);
        gen_traffic(60, 70000, 20);
        drain();
        write_reg(REG_FEATURES, 32'd1);
        write_reg(REG_GAINS, 32'h0102_0000);
        gen_traffic(40, 70000, 30);
        drain();

        // Long run of admissions without a tick: full ring and saturated count.
        write_reg(REG_PERCYCLE, 32'd255);
        write_reg(REG_BURST, 32'd64);
        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_FEATURES, 32'd6);
        for (int i = 0; i < 262; i++) begin
            cur_time = cur_time + $urandom_range(0, 3);
            push_req(FN_SUCCESS, cur_time, 2'd0, 2'd0, 1'b1);
        end
        push_req(FN_QUERY, cur_time, 2'd0, 2'd0, 1'b1);
        push_req(FN_TICK, cur_time + 1, 2'd0, 2'd0, 1'b1);
        drain();

        // Crossed clamps, zero burst limit, then random settings.
        write_reg(REG_MIN, 32'd900);
        write_reg(REG_MAX, 32'd300);
        write_reg(REG_BURST, 32'd0);
        write_reg(REG_FEATURES, 32'd7);
        write_reg(REG_BASE, 32'd0);
        gen_traffic(60, 100, 15);
        drain();
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_BASE, $urandom_range(0, 2000));
            write_reg(REG_MIN, $urandom_range(0, 200));
            write_reg(REG_MAX, $urandom_range(100, 8000));
            write_reg(REG_WINDOW, $urandom_range(0, 3000));
            write_reg(REG_BURST, $urandom_range(0, 70));
            write_reg(REG_PERCYCLE, $urandom_range(0, 8));
            write_reg(REG_GAINS, $urandom);
            write_reg(REG_FEATURES, $urandom_range(0, 7));
            gen_traffic(60, 200, 12);
            drain();
        end

        $display("Covered %0d requests with %0d admissions recorded; blocks by breaker %0d,",
                 req_count, admit_count, reason_hits[RSN_BREAKER]);
        $display("cycle limit %0d, burst %0d, spacing %0d; burst release seen: %0d.",
                 reason_hits[RSN_CYCLE], reason_hits[RSN_BURST], reason_hits[RSN_SPACING],
                 release_seen);
        if (err_count == 0)
            $display("adaptive_admission_throttle_tb: clean");
        else
            $display("adaptive_admission_throttle_tb: errors");
        $finish;
    end
endmodule
